// File: sv/jsu_pkg.sv
package jsu_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_TEXT,
		MODE_ESC,
		MODE_HEX
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_END_OK,
		KIND_TOO_LONG,
		KIND_FORMAT_ERR
	} kind_t;

	// One classified input byte: up to three result beats of the same kind.
	typedef struct packed {
		logic [1:0] n;
		kind_t      kind;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} cmd_t;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [10:0] MAX_LEN_RESET = 11'd64;

endpackage

// File: sv/jsu_front.sv
module jsu_front import jsu_pkg::*; #(
	parameter int LEN_LIMIT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	localparam int LW = $clog2(LEN_LIMIT + 1);
	localparam int CW = ((LW > 11) ? LW : 11) + 1;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	// Returns the digit value with a valid flag in the top bit.
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
		else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
			r = {1'b1, b[3:0] + 4'd9};
		return r;
	endfunction

	mode_t       mode_q, mode_d;
	logic [2:0]  hex_count_q, hex_count_d;
	logic [15:0] cp_q, cp_d;
	logic        hex_stopped_q, hex_stopped_d;
	logic [LW-1:0] len_q, len_d;
	logic [10:0] max_len_q;

	logic          accept;
	logic [4:0]    hv;
	logic          hex_take;
	logic [15:0]   cp_upd;
	logic [2:0]    cnt_inc;
	logic          hex_done;
	cmd_t          cmd;
	logic [1:0]    n_data;
	logic [LW:0]   len_sum;
	logic [CW-1:0] cap;
	logic [CW-1:0] len_plus;

	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	assign hv       = hex_val(s_tdata);
	assign hex_take = !hex_stopped_q && hv[4];
	assign cp_upd   = hex_take ? {cp_q[11:0], hv[3:0]} : cp_q;
	assign cnt_inc  = hex_count_q + 3'd1;
	assign hex_done = cnt_inc >= 3'd4;

	assign cap = (CW'(max_len_q) > CW'(LEN_LIMIT)) ? CW'(LEN_LIMIT) : CW'(max_len_q);
	assign len_plus = CW'(len_q) + CW'(1);

	assign n_data  = (cmd.kind == KIND_DATA) ? cmd.n : 2'd0;
	assign len_sum = (LW + 1)'(len_q) + (LW + 1)'(n_data);

	always_comb begin
		mode_d        = mode_q;
		hex_count_d   = hex_count_q;
		cp_d          = cp_q;
		hex_stopped_d = hex_stopped_q;
		len_d         = (len_sum > (LW + 1)'(LEN_LIMIT)) ? LW'(LEN_LIMIT) : len_sum[LW-1:0];
		unique case (mode_q)
			MODE_IDLE: begin
				if (s_tdata == CH_QUOTE) begin
					mode_d = MODE_TEXT;
					len_d  = '0;
				end
			end
			MODE_TEXT: begin
				if (s_tdata == CH_QUOTE) mode_d = MODE_IDLE;
				else if (s_tdata == CH_BSL) mode_d = MODE_ESC;
			end
			MODE_ESC: begin
				if (s_tdata == CH_U) begin
					mode_d        = MODE_HEX;
					hex_count_d   = 3'd0;
					cp_d          = 16'd0;
					hex_stopped_d = 1'b0;
				end else begin
					mode_d = MODE_TEXT;
				end
			end
			MODE_HEX: begin
				if (hex_done) begin
					mode_d        = MODE_TEXT;
					hex_count_d   = 3'd0;
					cp_d          = 16'd0;
					hex_stopped_d = 1'b0;
				end else begin
					hex_count_d   = cnt_inc;
					cp_d          = cp_upd;
					hex_stopped_d = !hex_take;
				end
			end
			default: mode_d = MODE_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.kind = KIND_DATA;
		unique case (mode_q)
			MODE_IDLE: begin
				if (s_tdata != CH_QUOTE && s_tdata != CH_SP && s_tdata != CH_TAB &&
				    s_tdata != CH_LF && s_tdata != CH_CR) begin
					cmd.n    = 2'd1;
					cmd.kind = KIND_FORMAT_ERR;
				end
			end
			MODE_TEXT: begin
				if (s_tdata == CH_QUOTE) begin
					cmd.n    = 2'd1;
					cmd.kind = (len_plus < cap) ? KIND_END_OK : KIND_TOO_LONG;
				end else if (s_tdata != CH_BSL) begin
					cmd.n  = 2'd1;
					cmd.b0 = s_tdata;
				end
			end
			MODE_ESC: begin
				if (s_tdata != CH_U) begin
					cmd.n = 2'd1;
					unique case (s_tdata)
						CH_B:    cmd.b0 = 8'h08;
						CH_F:    cmd.b0 = 8'h0C;
						CH_N:    cmd.b0 = 8'h0A;
						CH_R:    cmd.b0 = 8'h0D;
						CH_T:    cmd.b0 = 8'h09;
						default: cmd.b0 = s_tdata;
					endcase
				end
			end
			MODE_HEX: begin
				if (hex_done) begin
					if (cp_upd <= 16'd127) begin
						cmd.n  = 2'd1;
						cmd.b0 = cp_upd[7:0];
					end else if (cp_upd <= 16'd2047) begin
						cmd.n  = 2'd2;
						cmd.b0 = 8'b11000000 | {3'b000, cp_upd[10:6]};
						cmd.b1 = 8'b10000000 | {2'b00, cp_upd[5:0]};
					end else begin
						cmd.n  = 2'd3;
						cmd.b0 = 8'b11100000 | {4'b0000, cp_upd[15:12]};
						cmd.b1 = 8'b10000000 | {2'b00, cp_upd[11:6]};
						cmd.b2 = 8'b10000000 | {2'b00, cp_upd[5:0]};
					end
				end
			end
			default: cmd.n = 2'd0;
		endcase
	end

	assign q_cmd  = cmd;
	assign q_push = accept && (cmd.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			hex_count_q   <= 3'd0;
			cp_q          <= 16'd0;
			hex_stopped_q <= 1'b0;
			len_q         <= '0;
		end else if (accept) begin
			mode_q        <= mode_d;
			hex_count_q   <= hex_count_d;
			cp_q          <= cp_d;
			hex_stopped_q <= hex_stopped_d;
			len_q         <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

`ifndef SYNTHESIS
	a_hex_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		hex_count_q < 3'd4)
		else $error("hex digit count out of range");
	a_hex_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_HEX |-> (hex_count_q == 3'd0 && cp_q == 16'd0 && !hex_stopped_q))
		else $error("hex state not cleared outside an escape");
	a_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(LEN_LIMIT))
		else $error("decoded length beyond its limit");
`endif

endmodule

// File: sv/jsu_queue.sv
module jsu_queue import jsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full  = count_q == (QAW + 1)'(QDEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !pop) count_q <= count_q + (QAW + 1)'(1);
			else if (pop && !push) count_q <= count_q - (QAW + 1)'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW + 1)'(QDEPTH))
		else $error("queue count out of range");
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> head.n != 2'd0)
		else $error("queue holds an entry with no beats");
`endif

endmodule

// File: sv/jsu_back.sv
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_head,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic       m_tlast
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	kind_t      kind_q;
	logic       last_q;

	logic       load;
	logic       beat_last;
	logic [7:0] beat_byte;

	assign load      = !q_empty && (!valid_q || m_tready);
	assign beat_last = idx_q == (q_head.n - 2'd1);
	assign q_pop     = load && beat_last;

	always_comb begin
		unique case (idx_q)
			2'd0:    beat_byte = q_head.b0;
			2'd1:    beat_byte = q_head.b1;
			default: beat_byte = q_head.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
			if (load) idx_q <= beat_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= beat_byte;
			kind_q <= q_head.kind;
			last_q <= beat_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	a_partial_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> (!q_empty && idx_q < q_head.n))
		else $error("partly sent entry left the queue head");
	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> idx_q == 2'd0)
		else $error("beat index not restarted after pop");
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (valid_q && last_q))
		else $error("final beat of an entry not marked last");
`endif

endmodule

// File: sv/json_string_unescape_utf8.sv
// Channel | Dir | Handshake             | Payload
// s       | in  | s_tvalid / s_tready   | s_tdata[7:0] in_byte
// m       | out | m_tvalid / m_tready   | m_tdata[7:0] out_byte, m_tuser[1:0] kind, m_tlast
// cfg     | in  | cfg_valid / cfg_ready | cfg_data[10:0] max_len
//
// One input byte is accepted every cycle while the four-entry result queue has room.
// A byte's result beats pass through the result queue and the back end's output register to m_tdata.
// A \u escape yields up to three beats from one byte, drained by the back end at one a cycle while m_tready is high.
// s_tready falls only when the queue is full; cfg_ready is always high.
// Reset clears the parser state and restores max_len to 64; there is no clearing pass.
module json_string_unescape_utf8 import jsu_pkg::*; #(
	parameter int LEN_LIMIT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic q_empty;
	cmd_t q_head;

	jsu_front #(
		.LEN_LIMIT(LEN_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	jsu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	jsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
